@@ hw/rtl/cgov_pkg.sv @@
// cgov_pkg: widths, codes, register reset values and shared structs of the
// core hotplug governor. No dependencies; every other source file depends on it.
`default_nettype none

package cgov_pkg;

    localparam int FREQ_W     = 22;
    localparam int QUOT_W     = 16;
    localparam int PCT_W      = 7;
    localparam int RATE_W     = QUOT_W + PCT_W;
    localparam int TICK_W     = 8;
    localparam int CNT_W      = 3;
    localparam int CORE_W     = 2;
    localparam int MASK_W     = 4;
    localparam int ACT_W      = 2;
    localparam int PORT_TIME_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LOCK_W     = 32;
    localparam int MAX_LANES  = 4;

    localparam int DEF_NUM_CORES  = 4;
    localparam int DEF_MAX_ONLINE = 4;
    localparam int DEF_TIME_BITS  = 48;

    typedef logic [FREQ_W-1:0] t_freq;
    typedef logic [QUOT_W-1:0] t_quot;
    typedef logic [PCT_W-1:0]  t_pct;
    typedef logic [RATE_W-1:0] t_rate;
    typedef logic [TICK_W-1:0] t_tick;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [CORE_W-1:0] t_core;
    typedef logic [MASK_W-1:0] t_mask;
    typedef logic [ACT_W-1:0]  t_action;

    // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT, exact for 22-bit x
    localparam int DIV100_MUL_W = 23;
    localparam int DIV100_SHIFT = 29;
    localparam int PROD_W       = FREQ_W + DIV100_MUL_W;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 23'd5368710;

    localparam logic [17:0] TOUCH_INTERVAL_US = 18'd150000;

    localparam t_action ACT_NONE  = 2'd0;
    localparam t_action ACT_UP    = 2'd1;
    localparam t_action ACT_DOWN  = 2'd2;
    localparam t_action ACT_BOOST = 2'd3;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_TOUCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_ONLINE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_PERCENT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_PERCENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UP_TICKS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_TICKS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_CORES    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_MIN_FREQ = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_LOCK_US  = 3'd7;

    typedef struct packed {
        t_cnt              min_online;
        t_pct              up_percent;
        t_pct              down_percent;
        t_tick             up_ticks;
        t_tick             down_ticks;
        t_cnt              boost_cores;
        t_freq             boost_min_freq;
        logic [LOCK_W-1:0] boost_lock_us;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        min_online:     3'd1,
        up_percent:     7'd95,
        down_percent:   7'd80,
        up_ticks:       8'd1,
        down_ticks:     8'd1,
        boost_cores:    3'd2,
        boost_min_freq: 22'd1728000,
        boost_lock_us:  32'd500000
    };

    // what one lane reports about its core
    typedef struct packed {
        logic contrib;     // feeds the fastest-core rate
        logic new_min;     // became slowest when scanned in core order
        logic above_up;
        logic below_down;
        logic at_floor;
    } t_lane_res;

    typedef struct packed {
        t_action action;
        t_core   core_index;
        t_mask   new_online_mask;
    } t_result;

    typedef struct packed {
        t_tick ticks;
        logic  boost_stamp;
    } t_upd;

endpackage

`default_nettype wire

@@ hw/rtl/cgov_in_if.sv @@
// cgov_in_if: input channel of the governor, valid/ready plus one item.
// Depends on cgov_pkg for field types.
`default_nettype none

interface cgov_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  func;
    logic [cgov_pkg::PORT_TIME_W-1:0]      now_us;
    cgov_pkg::t_mask                       online_mask;
    cgov_pkg::t_freq                       max_freq_khz;
    cgov_pkg::t_freq                       freq_core0;
    cgov_pkg::t_freq                       freq_core1;
    cgov_pkg::t_freq                       freq_core2;
    cgov_pkg::t_freq                       freq_core3;

    modport source (
        output valid, func, now_us, online_mask, max_freq_khz,
               freq_core0, freq_core1, freq_core2, freq_core3,
        input  ready
    );
    modport sink (
        input  valid, func, now_us, online_mask, max_freq_khz,
               freq_core0, freq_core1, freq_core2, freq_core3,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/cgov_out_if.sv @@
// cgov_out_if: result channel of the governor, valid/ready plus one result.
// Depends on cgov_pkg for field types.
`default_nettype none

interface cgov_out_if;
    logic                valid;
    logic                ready;
    cgov_pkg::t_action   action;
    cgov_pkg::t_core     core_index;
    cgov_pkg::t_mask     new_online_mask;

    modport source (
        output valid, action, core_index, new_online_mask,
        input  ready
    );
    modport sink (
        input  valid, action, core_index, new_online_mask,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/cgov_cfg_if.sv @@
// cgov_cfg_if: register write channel, valid/ready with index and data.
// Depends on cgov_pkg for widths.
`default_nettype none

interface cgov_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [cgov_pkg::CFG_IDX_W-1:0]     index;
    logic [cgov_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/core_hotplug_governor.sv @@
// core_hotplug_governor: a per-core lane array and a merge stage decide, for
// each sampling tick or touch event, whether to bring a core up or down.
// Usage:
//   i_in   : one transaction per tick (func 0) or touch event (func 1), with
//            time, online mask, max frequency and per-core frequencies.
//   o_out  : exactly one result transaction per input transaction, in order:
//            action, core index and the online mask after the action.
//   i_cfg  : register writes by index (0 min_online .. 7 boost_lock_us),
//            always ready; write only while no transaction is in flight.
// Timing: three register stages (input + divide by 100, limits, output).
//   The result passes the input, limits and output registers in turn; one
//   transaction per cycle is sustained while o_out.ready is high. The limit
//   multiplies and the reciprocal divide each own a stage; the decision and
//   state update happen as a transaction leaves the limits stage.
// Reset: registers back to their defaults, tick counter and touch/boost
//   timestamps cleared, pipeline empty, i_in.ready high.
// Stall: when o_out.ready is low the result is held; i_in.ready stays high
//   until the two internal stages are also full.
// Depends on cgov_pkg, the three channel interfaces, cgov_cfg_regs,
// cgov_lane and cgov_merge.
`default_nettype none

module core_hotplug_governor #(
    parameter int NUM_CORES  = cgov_pkg::DEF_NUM_CORES,
    parameter int MAX_ONLINE = cgov_pkg::DEF_MAX_ONLINE,
    parameter int TIME_BITS  = cgov_pkg::DEF_TIME_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cgov_cfg_if.sink    i_cfg,
    cgov_in_if.sink     i_in,
    cgov_out_if.source  o_out
);
    import cgov_pkg::*;

    localparam int LANES = (NUM_CORES < MAX_LANES) ? NUM_CORES : MAX_LANES;

    t_cfg w_cfg;

    cgov_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // stage control: each stage loads when empty or when it drains
    logic r_s1_valid, r_s2_valid, r_o_valid;
    logic w_en_o, w_en_s2, w_en_s1, w_move2, w_move1, w_in_fire;

    assign w_en_o    = !r_o_valid || o_out.ready;
    assign w_move2   = r_s2_valid && w_en_o;
    assign w_en_s2   = !r_s2_valid || w_move2;
    assign w_move1   = r_s1_valid && w_en_s2;
    assign w_en_s1   = !r_s1_valid || w_move1;
    assign w_in_fire = i_in.valid && w_en_s1;

    assign i_in.ready = w_en_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_en_s1) r_s1_valid <= i_in.valid;
            if (w_en_s2) r_s2_valid <= r_s1_valid;
            if (w_en_o)  r_o_valid  <= r_s2_valid;
        end
    end

    // stage 1: capture, normalise the mask, divide max frequency by 100
    t_freq                w_port_rates [MAX_LANES];
    logic [PROD_W-1:0]    w_prod;
    logic [LANES-1:0]     w_in_mask;

    assign w_port_rates[0] = i_in.freq_core0;
    assign w_port_rates[1] = i_in.freq_core1;
    assign w_port_rates[2] = i_in.freq_core2;
    assign w_port_rates[3] = i_in.freq_core3;
    assign w_prod    = PROD_W'(i_in.max_freq_khz) * PROD_W'(DIV100_MUL);
    assign w_in_mask = LANES'(i_in.online_mask) | LANES'(1);

    logic                 r_s1_func;
    logic [TIME_BITS-1:0] r_s1_now;
    logic [LANES-1:0]     r_s1_mask;
    t_freq                r_s1_rates [LANES];
    t_quot                r_s1_quot;
    t_freq                r_s1_max;

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_func <= i_in.func;
            r_s1_now  <= TIME_BITS'(i_in.now_us);
            r_s1_mask <= w_in_mask;
            r_s1_quot <= w_prod[DIV100_SHIFT +: QUOT_W];
            r_s1_max  <= i_in.max_freq_khz;
            for (int k = 0; k < LANES; k++) begin
                r_s1_rates[k] <= w_port_rates[k];
            end
        end
    end

    // stage 2: up and down limits, boost floor
    logic                 r_s2_func;
    logic [TIME_BITS-1:0] r_s2_now;
    logic [LANES-1:0]     r_s2_mask;
    t_freq                r_s2_rates [LANES];
    t_rate                r_s2_up_rate;
    t_rate                r_s2_down_rate;
    t_freq                r_s2_floor;

    always_ff @(posedge i_clk) begin
        if (w_move1) begin
            r_s2_func      <= r_s1_func;
            r_s2_now       <= r_s1_now;
            r_s2_mask      <= r_s1_mask;
            r_s2_up_rate   <= t_rate'(r_s1_quot) * t_rate'(w_cfg.up_percent);
            r_s2_down_rate <= t_rate'(r_s1_quot) * t_rate'(w_cfg.down_percent);
            r_s2_floor     <= (r_s1_max <= w_cfg.boost_min_freq) ? r_s1_max
                                                                 : w_cfg.boost_min_freq;
            for (int k = 0; k < LANES; k++) begin
                r_s2_rates[k] <= r_s1_rates[k];
            end
        end
    end

    // lanes and merge
    t_lane_res w_lanes [LANES];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        cgov_lane #(
            .LANE  (g),
            .LANES (LANES)
        ) u_lane (
            .i_rates     (r_s2_rates),
            .i_mask      (r_s2_mask),
            .i_up_rate   (r_s2_up_rate),
            .i_down_rate (r_s2_down_rate),
            .i_floor     (r_s2_floor),
            .o_res       (w_lanes[g])
        );
    end

    logic [TIME_BITS-1:0] r_last_touch, r_last_boost;
    t_tick                r_ticks;
    t_result              w_result;
    t_upd                 w_upd;

    cgov_merge #(
        .LANES      (LANES),
        .MAX_ONLINE (MAX_ONLINE),
        .TIME_BITS  (TIME_BITS)
    ) u_merge (
        .i_lanes      (w_lanes),
        .i_mask       (r_s2_mask),
        .i_func       (r_s2_func),
        .i_now        (r_s2_now),
        .i_last_touch (r_last_touch),
        .i_last_boost (r_last_boost),
        .i_ticks      (r_ticks),
        .i_cfg        (w_cfg),
        .o_res        (w_result),
        .o_upd        (w_upd)
    );

    // governor state moves as each transaction leaves stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks      <= '0;
            r_last_touch <= '0;
            r_last_boost <= '0;
        end else if (w_move2) begin
            r_ticks <= w_upd.ticks;
            if (r_s2_func == FUNC_TOUCH) r_last_touch <= r_s2_now;
            if (w_upd.boost_stamp)       r_last_boost <= r_s2_now;
        end
    end

    t_result r_o_res;

    always_ff @(posedge i_clk) begin
        if (w_move2) begin
            r_o_res <= w_result;
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.action          = r_o_res.action;
    assign o_out.core_index      = r_o_res.core_index;
    assign o_out.new_online_mask = r_o_res.new_online_mask;

endmodule

`default_nettype wire

@@ hw/rtl/cgov_cfg_regs.sv @@
// cgov_cfg_regs: configuration register file of the governor.
// Depends on cgov_pkg and cgov_cfg_if.
`default_nettype none

module cgov_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cgov_cfg_if.sink       i_cfg,
    output cgov_pkg::t_cfg o_cfg
);
    import cgov_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MIN_ONLINE:     r_cfg.min_online     <= i_cfg.data[CNT_W-1:0];
                REG_UP_PERCENT:     r_cfg.up_percent     <= i_cfg.data[PCT_W-1:0];
                REG_DOWN_PERCENT:   r_cfg.down_percent   <= i_cfg.data[PCT_W-1:0];
                REG_UP_TICKS:       r_cfg.up_ticks       <= i_cfg.data[TICK_W-1:0];
                REG_DOWN_TICKS:     r_cfg.down_ticks     <= i_cfg.data[TICK_W-1:0];
                REG_BOOST_CORES:    r_cfg.boost_cores    <= i_cfg.data[CNT_W-1:0];
                REG_BOOST_MIN_FREQ: r_cfg.boost_min_freq <= i_cfg.data[FREQ_W-1:0];
                REG_BOOST_LOCK_US:  r_cfg.boost_lock_us  <= i_cfg.data[LOCK_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cgov_lane.sv @@
// cgov_lane: per-core compares of the governor, one copy per core.
// Depends on cgov_pkg.
`default_nettype none

module cgov_lane #(
    parameter int LANE  = 0,
    parameter int LANES = cgov_pkg::MAX_LANES
) (
    input  cgov_pkg::t_freq     i_rates [LANES],
    input  logic [LANES-1:0]    i_mask,
    input  cgov_pkg::t_rate     i_up_rate,
    input  cgov_pkg::t_rate     i_down_rate,
    input  cgov_pkg::t_freq     i_floor,
    output cgov_pkg::t_lane_res o_res
);
    import cgov_pkg::*;

    logic  w_new_min;
    t_rate w_rate;

    assign w_rate = t_rate'(i_rates[LANE]);

    // core 0 never competes for slowest; others win on <= every earlier online core above core 0
    always_comb begin
        w_new_min = (LANE != 0) && i_mask[LANE];
        for (int j = 1; j < LANES; j++) begin
            if (j < LANE && i_mask[j] && (i_rates[LANE] > i_rates[j])) begin
                w_new_min = 1'b0;
            end
        end
    end

    assign o_res.new_min    = w_new_min;
    assign o_res.contrib    = (LANE == 0) || (i_mask[LANE] && !w_new_min);
    assign o_res.above_up   = w_rate > i_up_rate;
    assign o_res.below_down = w_rate < i_down_rate;
    assign o_res.at_floor   = i_rates[LANE] >= i_floor;

endmodule

`default_nettype wire

@@ hw/rtl/cgov_merge.sv @@
// cgov_merge: combines the lane findings with the governor state into one
// decision and the next state. Depends on cgov_pkg.
`default_nettype none

module cgov_merge #(
    parameter int LANES      = cgov_pkg::MAX_LANES,
    parameter int MAX_ONLINE = cgov_pkg::DEF_MAX_ONLINE,
    parameter int TIME_BITS  = cgov_pkg::DEF_TIME_BITS
) (
    input  cgov_pkg::t_lane_res i_lanes [LANES],
    input  logic [LANES-1:0]    i_mask,
    input  logic                i_func,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [TIME_BITS-1:0] i_last_touch,
    input  logic [TIME_BITS-1:0] i_last_boost,
    input  cgov_pkg::t_tick     i_ticks,
    input  cgov_pkg::t_cfg      i_cfg,
    output cgov_pkg::t_result   o_res,
    output cgov_pkg::t_upd      o_upd
);
    import cgov_pkg::*;

    t_cnt             w_cnt;
    t_cnt             w_fill;
    logic             w_all_up;
    logic             w_fast_floor;
    logic             w_fast_below;
    logic             w_any_slow;
    t_core            w_slow_core;
    logic [LANES-1:0] w_slow_hot;
    logic             w_found;
    t_core            w_add_core;
    logic [LANES-1:0] w_add_hot;
    logic [LANES-1:0] w_boost_mask;
    logic             w_boost_recent;
    logic             w_touch_hold;
    logic             w_below_max;
    t_tick            w_tick_inc;
    logic [TIME_BITS-1:0] w_boost_age;
    logic [TIME_BITS-1:0] w_touch_age;

    assign w_boost_age    = i_now - i_last_boost;
    assign w_touch_age    = i_now - i_last_touch;
    assign w_boost_recent = w_boost_age < TIME_BITS'(TOUCH_INTERVAL_US);
    assign w_touch_hold   = w_touch_age < TIME_BITS'(i_cfg.boost_lock_us);
    assign w_tick_inc     = (i_ticks == '1) ? i_ticks : i_ticks + t_tick'(1);

    always_comb begin
        w_cnt        = '0;
        w_all_up     = 1'b1;
        w_fast_floor = 1'b0;
        w_fast_below = 1'b1;
        w_any_slow   = 1'b0;
        w_slow_core  = '0;
        w_slow_hot   = '0;
        for (int i = 0; i < LANES; i++) begin
            w_cnt = w_cnt + t_cnt'(i_mask[i]);
            if (i_mask[i] && !i_lanes[i].above_up) begin
                w_all_up = 1'b0;
            end
            if (i_lanes[i].contrib && i_lanes[i].at_floor) begin
                w_fast_floor = 1'b1;
            end
            if (i_lanes[i].contrib && !i_lanes[i].below_down) begin
                w_fast_below = 1'b0;
            end
            // last one to become slowest wins
            if (i_lanes[i].new_min) begin
                w_any_slow     = 1'b1;
                w_slow_core    = t_core'(i);
                w_slow_hot     = '0;
                w_slow_hot[i]  = 1'b1;
            end
        end
    end

    // lowest offline core above core 0
    always_comb begin
        w_found    = 1'b0;
        w_add_core = '0;
        w_add_hot  = '0;
        for (int i = LANES - 1; i >= 1; i--) begin
            if (!i_mask[i]) begin
                w_found       = 1'b1;
                w_add_core    = t_core'(i);
                w_add_hot     = '0;
                w_add_hot[i]  = 1'b1;
            end
        end
    end

    // touch boost raises offline cores from the lowest up to boost_cores online
    always_comb begin
        w_boost_mask = i_mask;
        w_fill       = w_cnt;
        for (int i = 1; i < LANES; i++) begin
            if (!i_mask[i] && (w_fill < i_cfg.boost_cores)) begin
                w_boost_mask[i] = 1'b1;
                w_fill          = w_fill + t_cnt'(1);
            end
        end
    end

    assign w_below_max = {1'b0, w_cnt} < (CNT_W + 1)'(MAX_ONLINE);

    always_comb begin
        o_res.action          = ACT_NONE;
        o_res.core_index      = '0;
        o_res.new_online_mask = t_mask'(i_mask);
        o_upd.ticks           = i_ticks;
        o_upd.boost_stamp     = 1'b0;
        if (i_func == FUNC_TOUCH) begin
            if (!(w_boost_recent || (w_cnt >= i_cfg.boost_cores) ||
                  (i_cfg.boost_cores <= i_cfg.min_online))) begin
                o_upd.boost_stamp = 1'b1;
                if (w_below_max) begin
                    o_res.action          = ACT_BOOST;
                    o_res.new_online_mask = t_mask'(w_boost_mask);
                end
            end
        end else begin
            o_upd.ticks = w_tick_inc;
            if (w_all_up && w_fast_floor) begin
                if (w_below_max && (w_tick_inc >= i_cfg.up_ticks)) begin
                    o_upd.ticks = '0;
                    if (w_found) begin
                        o_res.action          = ACT_UP;
                        o_res.core_index      = w_add_core;
                        o_res.new_online_mask = t_mask'(i_mask | w_add_hot);
                    end
                end
            end else if (w_any_slow && w_fast_below) begin
                if ((w_cnt > i_cfg.min_online) && (w_tick_inc >= i_cfg.down_ticks) &&
                    !((w_cnt <= i_cfg.boost_cores) && w_touch_hold)) begin
                    o_upd.ticks           = '0;
                    o_res.action          = ACT_DOWN;
                    o_res.core_index      = w_slow_core;
                    o_res.new_online_mask = t_mask'(i_mask & ~w_slow_hot);
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cgov_checker.sv @@
// cgov_checker: port-level assertions for core_hotplug_governor, attached
// by the bind at the end of this file. Depends on cgov_pkg.
`default_nettype none

module cgov_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input cgov_pkg::t_action   i_action,
    input cgov_pkg::t_core     i_core_index,
    input cgov_pkg::t_mask     i_mask
);
    import cgov_pkg::*;

    logic w_out_fire;
    assign w_out_fire = i_out_valid && i_out_ready;

    // a held result keeps its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_action) && $stable(i_core_index) && $stable(i_mask))
        else $error("result changed while stalled");

    // after reset the pipeline is empty and takes input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("pipeline not empty after reset");

    a_up_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire && (i_action == ACT_UP) |->
            (i_core_index != '0) && i_mask[i_core_index] && i_mask[0])
        else $error("core brought up is not in the new mask");

    a_down_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire && (i_action == ACT_DOWN) |->
            (i_core_index != '0) && !i_mask[i_core_index] && i_mask[0])
        else $error("core taken down is still in the new mask");

endmodule

bind core_hotplug_governor cgov_checker u_cgov_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_action     (o_out.action),
    .i_core_index (o_out.core_index),
    .i_mask       (o_out.new_online_mask)
);

`default_nettype wire

@@ bench/testbench.sv @@
// testbench: self-checking bench for core_hotplug_governor, a directed table then
// random ticks and touch events under several register settings, checked in order.
// Depends on cgov_pkg, cgov_in_if, cgov_out_if, cgov_cfg_if and the governor RTL.
`default_nettype none

module testbench;
    import cgov_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int ONLINE_CAP = DEF_MAX_ONLINE;

    typedef struct {
        logic               func;
        logic [47:0]        now_us;
        t_mask              online_mask;
        t_freq              max_freq_khz;
        t_freq [0:3]        freq;
    } t_stim;

    typedef struct {
        t_stim   s;
        bit      typed;
        t_result want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    cgov_in_if  in_ch ();
    cgov_out_if out_ch ();
    cgov_cfg_if cfg_ch ();

    core_hotplug_governor DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // governor state as the block should hold it
    t_cfg        cfg_now = CFG_RESET;
    logic [7:0]  tick_count = '0;
    logic [47:0] touch_stamp = '0;
    logic [47:0] boost_stamp = '0;

    t_result     pending_results [$];
    t_mask       sys_mask = 4'b0001;
    logic [47:0] sim_now = 48'd5000000;
    bit          failed = 0;
    bit          steady = 0;
    bit          holdoff_req = 0;
    int          burst_left = 0;
    t_result     want_now;

    // after-reset rows, extremes and the tie, floor, hold and wrap cases
    t_row script [0:16] = '{
        '{'{FUNC_TICK, 48'd1000, 4'b0001, 22'd2000000,
            '{22'd2000000, 22'd2000000, 22'd2000000, 22'd2000000}},
          1, '{ACT_UP, 2'd1, 4'b0011}},
        '{'{FUNC_TICK, 48'd2000, 4'b0011, 22'd2000000, '{22'd0, 22'd0, 22'd0, 22'd0}},
          1, '{ACT_NONE, 2'd0, 4'b0011}},
        '{'{FUNC_TICK, 48'd600000, 4'b0011, 22'd2000000, '{22'd0, 22'd0, 22'd0, 22'd0}},
          1, '{ACT_DOWN, 2'd1, 4'b0001}},
        '{'{FUNC_TOUCH, 48'd700000, 4'b0001, 22'd2000000, '{22'd0, 22'd0, 22'd0, 22'd0}},
          1, '{ACT_BOOST, 2'd0, 4'b0011}},
        '{'{FUNC_TOUCH, 48'd750000, 4'b0011, 22'd2000000, '{22'd0, 22'd0, 22'd0, 22'd0}},
          1, '{ACT_NONE, 2'd0, 4'b0011}},
        '{'{FUNC_TICK, 48'd800000, 4'b0011, 22'd2000000, '{22'd0, 22'd0, 22'd0, 22'd0}},
          1, '{ACT_NONE, 2'd0, 4'b0011}},
        '{'{FUNC_TICK, 48'd900000, 4'b1110, 22'd4194303,
            '{22'd4194303, 22'd4194303, 22'd4194303, 22'd4194303}},
          1, '{ACT_NONE, 2'd0, 4'b1111}},
        '{'{FUNC_TICK, 48'd950000, 4'b1111, 22'd0, '{22'd0, 22'd0, 22'd0, 22'd0}},
          1, '{ACT_NONE, 2'd0, 4'b1111}},
        '{'{FUNC_TICK, 48'd960000, 4'b1111, 22'd2000000,
            '{22'd1000000, 22'd500000, 22'd500000, 22'd900000}},
          0, '0},
        '{'{FUNC_TOUCH, 48'd1000000, 4'b0001, 22'd2000000, '{22'd0, 22'd0, 22'd0, 22'd0}},
          1, '{ACT_BOOST, 2'd0, 4'b0011}},
        '{'{FUNC_TOUCH, 48'hFFFF_FFFF_FF9C, 4'b0011, 22'd2000000,
            '{22'd0, 22'd0, 22'd0, 22'd0}},
          1, '{ACT_NONE, 2'd0, 4'b0011}},
        '{'{FUNC_TICK, 48'd50, 4'b0011, 22'd2000000, '{22'd0, 22'd0, 22'd0, 22'd0}},
          0, '0},
        '{'{FUNC_TOUCH, 48'd100, 4'b0001, 22'd2000000, '{22'd0, 22'd0, 22'd0, 22'd0}},
          0, '0},
        '{'{FUNC_TICK, 48'd2000, 4'b0011, 22'd1000000,
            '{22'd995000, 22'd1000000, 22'd0, 22'd0}},
          0, '0},
        '{'{FUNC_TOUCH, 48'hFFFF_FFFF_FFFF, 4'b1111, 22'd4194303,
            '{22'd4194303, 22'd4194303, 22'd4194303, 22'd4194303}},
          0, '0},
        '{'{FUNC_TICK, 48'd4000, 4'b0000, 22'd4194303,
            '{22'd4194303, 22'd4194303, 22'd4194303, 22'd4194303}},
          0, '0},
        '{'{FUNC_TICK, 48'd5000, 4'b1111, 22'd4194303, '{22'd1, 22'd1, 22'd1, 22'd1}},
          0, '0}
    };

    function automatic t_result govern_step(input t_stim s);
        t_mask        m;
        int unsigned  online;
        int unsigned  quot;
        int unsigned  up_lim;
        int unsigned  down_lim;
        logic [47:0]  now;
        t_freq        c0;
        t_freq        fastest;
        t_freq        slowest;
        t_freq        rate;
        t_freq        flr;
        bit           slow_seen;
        int unsigned  slow_core;
        t_result      r;

        now = s.now_us;
        m = s.online_mask | 4'b0001;
        online = $countones(m);
        r.action = ACT_NONE;
        r.core_index = '0;
        r.new_online_mask = m;

        if (s.func == FUNC_TOUCH) begin
            touch_stamp = now;
            if (48'(now - boost_stamp) < 48'(TOUCH_INTERVAL_US) ||
                online >= cfg_now.boost_cores || cfg_now.boost_cores <= cfg_now.min_online)
                return r;
            boost_stamp = now;
            if (online >= ONLINE_CAP)
                return r;
            for (int i = 1; i < 4; i++) begin
                if (online >= cfg_now.boost_cores)
                    break;
                if (!m[i]) begin
                    m[i] = 1'b1;
                    online++;
                end
            end
            r.action = ACT_BOOST;
            r.new_online_mask = m;
            return r;
        end

        if (tick_count != 8'hFF)
            tick_count++;

        quot = int'(s.max_freq_khz) / 100;
        up_lim = quot * int'(cfg_now.up_percent);
        down_lim = quot * int'(cfg_now.down_percent);
        c0 = s.freq[0];
        fastest = c0;
        slowest = '0;
        slow_seen = 0;
        slow_core = 0;
        flr = cfg_now.boost_min_freq;

        // a core that becomes the slowest is not looked at for the fastest
        for (int i = 1; i < 4; i++) begin
            if (m[i]) begin
                rate = s.freq[i];
                if (!slow_seen || rate <= slowest) begin
                    slow_seen = 1;
                    slow_core = i;
                    slowest = rate;
                end else if (rate > fastest) begin
                    fastest = rate;
                end
            end
        end
        if (!slow_seen || c0 < slowest)
            slowest = c0;
        if (s.max_freq_khz <= flr)
            flr = s.max_freq_khz;

        if (slowest > up_lim && fastest >= flr) begin
            if (online < ONLINE_CAP && tick_count >= cfg_now.up_ticks) begin
                tick_count = '0;
                for (int i = 1; i < 4; i++) begin
                    if (!m[i]) begin
                        m[i] = 1'b1;
                        r.action = ACT_UP;
                        r.core_index = t_core'(i);
                        r.new_online_mask = m;
                        return r;
                    end
                end
            end
        end else if (slow_core != 0 && fastest < down_lim) begin
            if (online > cfg_now.min_online && tick_count >= cfg_now.down_ticks) begin
                // recent touch keeps the boosted cores up
                if (online <= cfg_now.boost_cores &&
                    48'(now - touch_stamp) < 48'(cfg_now.boost_lock_us))
                    return r;
                tick_count = '0;
                m[slow_core] = 1'b0;
                r.action = ACT_DOWN;
                r.core_index = t_core'(slow_core);
                r.new_online_mask = m;
                return r;
            end
        end
        return r;
    endfunction

    function automatic t_stim make_item();
        t_stim       s;
        int unsigned upl;
        int unsigned dnl;
        int unsigned lo;
        int unsigned hi;
        int unsigned v;
        int unsigned pick;

        s.func = ($urandom_range(0, 99) < 12) ? FUNC_TOUCH : FUNC_TICK;
        if ($urandom_range(0, 99) < 10) begin
            s.now_us = {16'($urandom), 32'($urandom)};
            s.online_mask = t_mask'($urandom);
            s.max_freq_khz = t_freq'($urandom);
            for (int i = 0; i < 4; i++)
                s.freq[i] = t_freq'($urandom);
            return s;
        end

        if ($urandom_range(0, 99) < 5)
            sim_now += 48'($urandom_range(150000, 2000000));
        else
            sim_now += 48'($urandom_range(5000, 60000));
        s.now_us = sim_now;
        s.online_mask = ($urandom_range(0, 9) == 0) ? t_mask'($urandom) : sys_mask;

        pick = $urandom_range(0, 9);
        if (pick == 0)
            s.max_freq_khz = t_freq'($urandom_range(0, 4194303));
        else if (pick == 1)
            s.max_freq_khz = 22'd4194303;
        else
            s.max_freq_khz = 22'd2265600;

        upl = (int'(s.max_freq_khz) / 100) * int'(cfg_now.up_percent);
        dnl = (int'(s.max_freq_khz) / 100) * int'(cfg_now.down_percent);
        hi = s.max_freq_khz;
        case ($urandom_range(0, 3))
            0: begin
                lo = (upl >= hi) ? hi : upl + 1;
                for (int i = 0; i < 4; i++)
                    s.freq[i] = t_freq'($urandom_range(lo, hi));
                s.freq[$urandom_range(0, 3)] = s.max_freq_khz;
            end
            1: begin
                lo = (dnl == 0) ? 0 : dnl - 1;
                for (int i = 0; i < 4; i++)
                    s.freq[i] = t_freq'($urandom_range(0, lo));
            end
            2: begin
                v = $urandom_range(0, hi);
                for (int i = 0; i < 4; i++)
                    s.freq[i] = t_freq'(v);
                if ($urandom_range(0, 1) == 1)
                    s.freq[$urandom_range(0, 3)] = t_freq'($urandom_range(0, hi));
            end
            default: begin
                for (int i = 0; i < 4; i++)
                    s.freq[i] = t_freq'($urandom_range(0, hi));
            end
        endcase
        return s;
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.min_online = t_cnt'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) :
                                                            $urandom_range(1, 2));
        c.up_percent = t_pct'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 100) :
                                                            $urandom_range(50, 100));
        c.down_percent = t_pct'($urandom_range(0, 100));
        c.up_ticks = t_tick'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) :
                                                           $urandom_range(0, 4));
        c.down_ticks = t_tick'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) :
                                                             $urandom_range(0, 4));
        c.boost_cores = t_cnt'($urandom_range(1, 4));
        c.boost_min_freq = t_freq'(($urandom_range(0, 9) < 3) ? $urandom_range(0, 4194303) :
                                                                $urandom_range(1000000, 2265600));
        c.boost_lock_us = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000000);
        return c;
    endfunction

    task automatic send_item(input t_stim s, input bit typed, input t_result want);
        t_result predicted;
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.func = s.func;
        in_ch.now_us = s.now_us;
        in_ch.online_mask = s.online_mask;
        in_ch.max_freq_khz = s.max_freq_khz;
        in_ch.freq_core0 = s.freq[0];
        in_ch.freq_core1 = s.freq[1];
        in_ch.freq_core2 = s.freq[2];
        in_ch.freq_core3 = s.freq[3];
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predicted = govern_step(s);
        sys_mask = predicted.new_online_mask;
        pending_results.push_back(typed ? want : predicted);
    endtask

    // sender bursts with gaps between them
    task automatic pace();
        int gap;
        if (steady)
            return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
    endtask

    task automatic program_regs(input t_cfg c);
        write_reg(REG_MIN_ONLINE, 32'(c.min_online));
        write_reg(REG_UP_PERCENT, 32'(c.up_percent));
        write_reg(REG_DOWN_PERCENT, 32'(c.down_percent));
        write_reg(REG_UP_TICKS, 32'(c.up_ticks));
        write_reg(REG_DOWN_TICKS, 32'(c.down_ticks));
        write_reg(REG_BOOST_CORES, 32'(c.boost_cores));
        write_reg(REG_BOOST_MIN_FREQ, 32'(c.boost_min_freq));
        write_reg(REG_BOOST_LOCK_US, c.boost_lock_us);
        cfg_now = c;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // drain the pipeline before touching the registers
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random stall pattern, a long hold-off on request
    initial begin
        int hold_cnt;
        int pat_age;
        int pos;
        logic [31:0] stall_pat;
        hold_cnt = 0;
        pat_age = 0;
        pos = 0;
        stall_pat = '1;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready = 1'b0;
            end else if (holdoff_req) begin
                holdoff_req = 0;
                hold_cnt = HOLDOFF_CYCLES - 1;
                out_ch.ready = 1'b0;
            end else if (steady) begin
                out_ch.ready = 1'b1;
            end else begin
                if (pat_age == 0) begin
                    stall_pat = $urandom;
                    pat_age = $urandom_range(20, 80);
                end
                pat_age--;
                pos = (pos + 1) % 32;
                out_ch.ready = stall_pat[pos] | stall_pat[(pos + 7) % 32];
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                failed = 1;
            end else begin
                want_now = pending_results.pop_front();
                if (out_ch.action !== want_now.action) begin
                    $error("action: expected %0d, got %0d", want_now.action, out_ch.action);
                    failed = 1;
                end
                if (out_ch.core_index !== want_now.core_index) begin
                    $error("core_index: expected %0d, got %0d",
                           want_now.core_index, out_ch.core_index);
                    failed = 1;
                end
                if (out_ch.new_online_mask !== want_now.new_online_mask) begin
                    $error("new_online_mask: expected %b, got %b",
                           want_now.new_online_mask, out_ch.new_online_mask);
                    failed = 1;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        t_cfg phase_cfg;
        int   phase_items;

        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_TICK;
        in_ch.now_us = '0;
        in_ch.online_mask = '0;
        in_ch.max_freq_khz = '0;
        in_ch.freq_core0 = '0;
        in_ch.freq_core1 = '0;
        in_ch.freq_core2 = '0;
        in_ch.freq_core3 = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[k]) begin
            send_item(script[k].s, script[k].typed, script[k].want);
            pace();
        end
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: phase_cfg = CFG_RESET;
                1: phase_cfg = '{3'd1, 7'd0, 7'd0, 8'd0, 8'd0, 3'd1, 22'd0, 32'd0};
                2: phase_cfg = '{3'd4, 7'd100, 7'd100, 8'd255, 8'd255, 3'd4,
                                 22'd4194303, 32'hFFFF_FFFF};
                default: phase_cfg = rand_cfg();
            endcase
            phase_items = (phase == 2) ? 400 : 280;
            steady = (phase == 2);
            if (phase == 4)
                sim_now = 48'hFFFF_FFF0_0000;
            program_regs(phase_cfg);
            for (int n = 0; n < phase_items; n++) begin
                send_item(make_item(), 0, '0);
                pace();
                if (phase == 3 && n == 100)
                    holdoff_req = 1;
            end
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/cgov_pkg.sv
hw/rtl/cgov_in_if.sv
hw/rtl/cgov_out_if.sv
hw/rtl/cgov_cfg_if.sv
hw/rtl/cgov_cfg_regs.sv
hw/rtl/cgov_lane.sv
hw/rtl/cgov_merge.sv
hw/rtl/core_hotplug_governor.sv
hw/rtl/cgov_checker.sv
bench/testbench.sv
